### design/assert_macros.svh
// Assertion macros, included by sorted_key_buffer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### design/skb_pkg.sv
// Types and constants shared by the sorted key buffer files.
package skb_pkg;

    localparam int DEPTH  = 16;
    localparam int KEY_W  = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CFG_W  = 5;
    localparam int RANK_W = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_RANK   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_INSERT       = 2'd0,
        MODE_INSERT_EVICT = 2'd1,
        MODE_POP          = 2'd2,
        MODE_HOLD         = 2'd3
    } t_cell_mode;

    typedef struct packed {
        logic       upd;
        t_cell_mode mode;
    } t_cell_ctl;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] key;
    } t_skb_item;

    typedef struct packed {
        logic               out_valid;
        logic signed [31:0] out_key;
        logic [4:0]         rank;
        logic [4:0]         fill_count;
        logic signed [31:0] smallest;
        logic signed [31:0] largest;
        logic               is_empty;
        logic               is_full;
    } t_skb_result;

endpackage

### design/sorted_key_buffer.sv
// Top level of the sorted key buffer: a row of compare-and-shift cells.
//
//  channel   | direction | transfer when        | payload
//  ----------+-----------+----------------------+---------------------------
//  command   | in        | start && !busy       | i_item (opcode, key)
//  result    | out       | o_strobe             | o_result (status, keys)
//  config    | in        | i_cfg_we             | i_cfg_wdata (capacity)
//
// For every command all cells compare against the broadcast key. On an insert,
// or a non-empty pop, they shift one place; the result strobes the next cycle.
// busy stays low, so a command may be issued every cycle.
// Reset (synchronous) clears the fill count and sets capacity to 16; the key
// cells are not cleared, only cells below the fill count are ever read.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_key_buffer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  skb_pkg::t_skb_item    i_item,
    output logic                  o_strobe,
    output skb_pkg::t_skb_result  o_result,
    input  logic                  i_cfg_we,
    input  logic [skb_pkg::CFG_W-1:0] i_cfg_wdata
);
    import skb_pkg::*;

    localparam int WIDE_W = CNT_W + CFG_W;

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [CFG_W-1:0]        r_cap;
    logic                    r_strobe;
    logic                    r_valid;
    logic signed [KEY_W-1:0] r_out_key;
    logic [RANK_W-1:0]       r_rank;

    logic                    accept;
    logic [1:0]              op;
    logic [WIDE_W-1:0]       cap_wide;
    logic [CNT_W-1:0]        cap_eff;
    logic                    evict;
    logic                    pop_ok;
    logic                    take_key;
    t_cell_ctl               ctl;

    logic signed [KEY_W-1:0] w_key [DEPTH];
    logic [DEPTH-1:0]        w_le;
    logic [DEPTH-1:0]        w_lt;
    logic [DEPTH-1:0]        w_occ;
    logic [DEPTH:0]          boundary;
    logic [CNT_W-1:0]        rank_full;
    logic signed [KEY_W-1:0] largest;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign op     = i_item.opcode;

    // Clamp the capacity register into 1 .. DEPTH
    assign cap_wide = WIDE_W'(r_cap);
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (cap_wide > WIDE_W'(DEPTH)) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(cap_wide);
        end
    end

    assign evict    = (r_count >= cap_eff);
    assign pop_ok   = (r_count != '0);
    assign take_key = ((op == OP_INSERT) && evict) || ((op == OP_POP) && pop_ok);

    // Drive the row control
    always_comb begin
        ctl.upd  = accept && ((op == OP_INSERT) || ((op == OP_POP) && pop_ok));
        ctl.mode = MODE_HOLD;
        case (op)
            OP_INSERT: ctl.mode = evict ? MODE_INSERT_EVICT : MODE_INSERT;
            OP_POP:    ctl.mode = MODE_POP;
            default:   ctl.mode = MODE_HOLD;
        endcase
    end

    // Build the cell row, neighbors wired left and right
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_occ[g] = (CNT_W'(g) < r_count);
        skb_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_new_key  (i_item.key),
            .i_occ      (w_occ[g]),
            .i_first    (g == 0),
            .i_prev_key ((g == 0) ? i_item.key : w_key[(g == 0) ? 0 : g - 1]),
            .i_prev_le  ((g == 0) ? 1'b1 : w_le[(g == 0) ? 0 : g - 1]),
            .i_next_key (w_key[(g == DEPTH - 1) ? g : g + 1]),
            .i_next_le  ((g == DEPTH - 1) ? 1'b0 : w_le[(g == DEPTH - 1) ? g : g + 1]),
            .o_key      (w_key[g]),
            .o_le       (w_le[g]),
            .o_lt       (w_lt[g])
        );
    end

    // Find the edge of the less-than prefix and encode its position
    always_comb begin
        boundary  = '0;
        rank_full = '0;
        for (int j = 0; j <= DEPTH; j++) begin
            boundary[j] = ((j == 0) ? 1'b1 : w_lt[(j == 0) ? 0 : j - 1])
                       && !((j == DEPTH) ? 1'b0 : w_lt[(j == DEPTH) ? 0 : j]);
        end
        for (int j = 0; j <= DEPTH; j++) begin
            if (boundary[j]) begin
                rank_full = rank_full | CNT_W'(j);
            end
        end
    end

    // Next fill count
    always_comb begin
        n_count = r_count;
        if (accept) begin
            if ((op == OP_INSERT) && !evict) begin
                n_count = r_count + CNT_W'(1);
            end else if ((op == OP_POP) && pop_ok) begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cap    <= CFG_W'(16);
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= accept;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // Capture the per-command result fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_valid   <= take_key;
            r_out_key <= take_key ? w_key[0] : '0;
            r_rank    <= (op == OP_RANK) ? RANK_W'(rank_full) : '0;
        end
    end

    // Select the last occupied cell for the largest key
    always_comb begin
        largest = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_count == CNT_W'(i + 1)) begin
                largest = largest | w_key[i];
            end
        end
    end

    // Drive the result
    assign o_strobe            = r_strobe;
    assign o_result.out_valid  = r_valid;
    assign o_result.out_key    = r_out_key;
    assign o_result.rank       = r_rank;
    assign o_result.fill_count = 5'(r_count);
    assign o_result.smallest   = pop_ok ? w_key[0] : '0;
    assign o_result.largest    = largest;
    assign o_result.is_empty   = !pop_ok;
    assign o_result.is_full    = evict;

`include "assert_macros.svh"

    `ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `ASSERT_NEXT(a_pop_empty, i_clk, i_rst_n,
        accept && (op == OP_POP) && !pop_ok, o_strobe && !o_result.out_valid)
    `ASSERT_NEXT(a_insert_fills, i_clk, i_rst_n,
        accept && (op == OP_INSERT), o_strobe && !o_result.is_empty)
    `ASSERT_NEXT(a_rank_state, i_clk, i_rst_n,
        accept && (op == OP_RANK), o_strobe && $stable(r_count))

endmodule

### design/skb_cell.sv
// One compare-and-shift cell of the sorted key row.
module skb_cell (
    input  logic                      i_clk,
    input  skb_pkg::t_cell_ctl        i_ctl,
    input  logic signed [skb_pkg::KEY_W-1:0] i_new_key,
    input  logic                      i_occ,
    input  logic                      i_first,
    input  logic signed [skb_pkg::KEY_W-1:0] i_prev_key,
    input  logic                      i_prev_le,
    input  logic signed [skb_pkg::KEY_W-1:0] i_next_key,
    input  logic                      i_next_le,
    output logic signed [skb_pkg::KEY_W-1:0] o_key,
    output logic                      o_le,
    output logic                      o_lt
);
    import skb_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;

    // Compare the held key against the broadcast key
    assign o_le  = i_occ && (r_key <= i_new_key);
    assign o_lt  = i_occ && (r_key <  i_new_key);
    assign o_key = r_key;

    // Pick the next key from self, neighbors or the new key
    always_comb begin
        case (i_ctl.mode)
            MODE_INSERT: begin
                if (o_le) begin
                    n_key = r_key;
                end else if (i_prev_le) begin
                    n_key = i_new_key;
                end else begin
                    n_key = i_prev_key;
                end
            end
            MODE_INSERT_EVICT: begin
                if (i_next_le) begin
                    n_key = i_next_key;
                end else if (i_first || o_le) begin
                    n_key = i_new_key;
                end else begin
                    n_key = r_key;
                end
            end
            MODE_POP: n_key = i_next_key;
            default:  n_key = r_key;
        endcase
    end

    // Hold the key unless an update is issued
    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            r_key <= n_key;
        end
    end

endmodule
